FILE: design/tvfs_pkg.sv
// Shared types and constants for the trilinear vector field sampler.
// No dependencies; imported by the top level, tvfs_mul and tvfs_core.
package tvfs_pkg;

   localparam int unsigned TVFS_DIM_X    = 32;
   localparam int unsigned TVFS_DIM_Y    = 32;
   localparam int unsigned TVFS_DIM_Z    = 32;
   localparam int unsigned STORE_DEPTH   = 32768;
   localparam int unsigned STORE_AW      = 15;
   localparam int unsigned BASE_W        = 8;
   localparam int unsigned FRAC_W        = 17;
   localparam int unsigned ACC_W         = 34;
   localparam int unsigned CSR_IDX_W     = 3;
   localparam int unsigned ENTRY_W       = 48;
   localparam logic [31:0] INV_STEP_RESET = 32'h0001_0000;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_STEP_X = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_STEP_Y = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_STEP_Z = 3'd5;

   typedef struct packed {
      logic                       cmd;
      logic [STORE_AW-1:0]        entry_index;
      logic signed [15:0]         entry_vx;
      logic signed [15:0]         entry_vy;
      logic signed [15:0]         entry_vz;
      logic signed [31:0]         pos_x;
      logic signed [31:0]         pos_y;
      logic signed [31:0]         pos_z;
   } req_word_type;

   typedef struct packed {
      logic                       inside_res;
      logic signed [15:0]         out_vx;
      logic signed [15:0]         out_vy;
      logic signed [15:0]         out_vz;
   } rsp_word_type;

   typedef struct packed {
      logic signed [15:0]         vx;
      logic signed [15:0]         vy;
      logic signed [15:0]         vz;
   } grid_entry_type;

   // operands for the shared multiplier: unsigned a, signed b
   typedef struct packed {
      logic [32:0]                a;
      logic signed [17:0]         b;
   } mul_op_type;

endpackage

FILE: design/trilinear_vector_field_sampler.sv
// Top level of the trilinear vector field sampler: registers, grid RAM, sequencer.
// Depends on tvfs_pkg, tvfs_ram, tvfs_mul and tvfs_core.
//
// A grid write (cmd 0) is taken in the cycle start is seen with busy low and
// leaves busy low, so writes may stream one per cycle. A sample (cmd 1)
// raises busy and gives one word on rsp_* with rsp_valid high for a single
// cycle; the receiver cannot hold it off and must take it then. The next
// word can be accepted in that same strobe cycle. A point outside the grid
// skips the corner walk. The pace is set by the one shared multiplier: two
// products per axis to map the point, then five per corner (two for the
// weight, three for the vector) over eight corners, each corner read from
// the read port of the grid RAM. Register writes on csr_* are always taken
// and belong in idle periods.
module trilinear_vector_field_sampler
   import tvfs_pkg::*;
#(
   parameter int unsigned DIM_X = TVFS_DIM_X,
   parameter int unsigned DIM_Y = TVFS_DIM_Y,
   parameter int unsigned DIM_Z = TVFS_DIM_Z
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_word_type         req_data,
   output logic                 rsp_valid,
   output rsp_word_type         rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]          csr_wdata
);

   logic [2:0][31:0]    origin_ff, origin_in;
   logic [2:0][31:0]    inv_step_ff, inv_step_in;
   logic                core_busy;
   logic                grid_wr_en;
   grid_entry_type      grid_wr_data;
   logic [STORE_AW-1:0] grid_rd_addr;
   logic [ENTRY_W-1:0]  grid_rd_raw;
   grid_entry_type      grid_rd_data;
   logic                start_query;

   assign csr_ready = 1'b1;

   always_comb begin
      origin_in   = origin_ff;
      inv_step_in = inv_step_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN_X:   origin_in[0]   = csr_wdata;
            CSR_ORIGIN_Y:   origin_in[1]   = csr_wdata;
            CSR_ORIGIN_Z:   origin_in[2]   = csr_wdata;
            CSR_INV_STEP_X: inv_step_in[0] = csr_wdata;
            CSR_INV_STEP_Y: inv_step_in[1] = csr_wdata;
            CSR_INV_STEP_Z: inv_step_in[2] = csr_wdata;
            default: begin
               origin_in = origin_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff   <= '0;
         inv_step_ff <= {3{INV_STEP_RESET}};
      end else begin
         origin_ff   <= origin_in;
         inv_step_ff <= inv_step_in;
      end
   end

   assign grid_wr_en   = start && !core_busy && (req_data.cmd == CMD_WRITE);
   assign start_query  = start && !core_busy && (req_data.cmd == CMD_SAMPLE);
   assign grid_wr_data = '{vx: req_data.entry_vx, vy: req_data.entry_vy,
                           vz: req_data.entry_vz};
   assign grid_rd_data = grid_entry_type'(grid_rd_raw);

   tvfs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (grid_wr_en),
      .wr_addr (req_data.entry_index),
      .wr_data (ENTRY_W'(grid_wr_data)),
      .rd_addr (grid_rd_addr),
      .rd_data (grid_rd_raw)
   );

   tvfs_core #(
      .DIM_X (DIM_X),
      .DIM_Y (DIM_Y),
      .DIM_Z (DIM_Z)
   ) u_core (
      .clock       (clock),
      .reset       (reset),
      .start_query (start_query),
      .req_data    (req_data),
      .origin      (origin_ff),
      .inv_step    (inv_step_ff),
      .rd_addr     (grid_rd_addr),
      .rd_data     (grid_rd_data),
      .busy        (core_busy),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

   assign busy = core_busy;

endmodule

FILE: design/tvfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tvfs_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 32768
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/tvfs_mul.sv
// Shared 33 x 18 multiplier with a registered product.
// Depends on tvfs_pkg for the operand struct.
module tvfs_mul
   import tvfs_pkg::*;
(
   input  logic               clock,
   input  mul_op_type         op,
   output logic signed [51:0] prod
);

   logic signed [51:0] prod_ff;
   logic signed [51:0] prod_in;

   always_comb begin
      prod_in = $signed({1'b0, op.a}) * op.b;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

FILE: design/tvfs_core.sv
// Query sequencer: maps the point per axis, then walks the eight corners
// if inside, driving the shared multiplier and grid read port. Uses tvfs_pkg.
module tvfs_core
   import tvfs_pkg::*;
#(
   parameter int unsigned DIM_X = TVFS_DIM_X,
   parameter int unsigned DIM_Y = TVFS_DIM_Y,
   parameter int unsigned DIM_Z = TVFS_DIM_Z
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start_query,
   input  req_word_type        req_data,
   input  logic [2:0][31:0]    origin,
   input  logic [2:0][31:0]    inv_step,
   output logic [STORE_AW-1:0] rd_addr,
   input  grid_entry_type      rd_data,
   output logic                busy,
   output logic                rsp_valid,
   output rsp_word_type        rsp_data
);

   typedef enum logic [11:0] {
      ST_IDLE   = 12'b0000_0000_0001,
      ST_MUL_LO = 12'b0000_0000_0010,
      ST_MUL_HI = 12'b0000_0000_0100,
      ST_AXIS   = 12'b0000_0000_1000,
      ST_ADDR   = 12'b0000_0001_0000,
      ST_WXY    = 12'b0000_0010_0000,
      ST_WZ     = 12'b0000_0100_0000,
      ST_VX     = 12'b0000_1000_0000,
      ST_VY     = 12'b0001_0000_0000,
      ST_VZ     = 12'b0010_0000_0000,
      ST_NEXT   = 12'b0100_0000_0000,
      ST_DONE   = 12'b1000_0000_0000
   } state_type;

   localparam logic [1:0] AX_X = 2'd0;
   localparam logic [1:0] AX_Y = 2'd1;
   localparam logic [1:0] AX_Z = 2'd2;

   localparam logic [STORE_AW-1:0] OFF_Y = STORE_AW'(DIM_X);
   localparam logic [STORE_AW-1:0] OFF_Z = STORE_AW'(DIM_X * DIM_Y);
   localparam logic [FRAC_W-1:0]   ONE_Q16 = FRAC_W'(65536);

   state_type                 state_ff, state_in;
   logic [1:0]                ax_ff, ax_in;
   logic [2:0]                corner_ff, corner_in;
   logic [2:0][32:0]          d_ff, d_in;
   logic [2:0][BASE_W-1:0]    base_ff, base_in;
   logic [2:0][FRAC_W-1:0]    frac_ff, frac_in;
   logic                      outside_ff, outside_in;
   logic [47:0]               l_lo_ff, l_lo_in;
   logic [STORE_AW-1:0]       base_addr_ff, base_addr_in;
   logic [FRAC_W-1:0]         w_ff, w_in;
   logic [2:0][ACC_W-1:0]     acc_ff, acc_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rsp_word_type              rsp_data_ff, rsp_data_in;

   mul_op_type                mul_op;
   logic signed [51:0]        prod;

   logic [32:0]               d_sel;
   logic [31:0]               inv_sel;
   logic [31:0]               dm1_sel;
   logic [63:0]               l_full;
   logic                      ax_out;
   logic [BASE_W-1:0]         ax_base;
   logic [FRAC_W-1:0]         ax_frac;
   logic [FRAC_W-1:0]         wx, wy, wz;
   logic [STORE_AW-1:0]       row_addr;
   logic [STORE_AW-1:0]       corner_off;
   logic [ACC_W-1:0]          prod_acc;
   logic [2:0][ACC_W-1:0]     rounded;

   tvfs_mul u_mul (
      .clock (clock),
      .op    (mul_op),
      .prod  (prod)
   );

   // per-axis operand selection
   always_comb begin
      case (ax_ff)
         AX_X: begin
            d_sel   = d_ff[0];
            inv_sel = inv_step[0];
            dm1_sel = 32'(DIM_X - 1);
         end
         AX_Y: begin
            d_sel   = d_ff[1];
            inv_sel = inv_step[1];
            dm1_sel = 32'(DIM_Y - 1);
         end
         default: begin
            d_sel   = d_ff[2];
            inv_sel = inv_step[2];
            dm1_sel = 32'(DIM_Z - 1);
         end
      endcase
   end

   // grid coordinate of the axis: low partial plus high partial shifted up
   always_comb begin
      l_full  = {16'b0, l_lo_ff} + {prod[47:0], 16'b0};
      ax_out  = 1'b0;
      ax_base = '0;
      ax_frac = '0;
      if (inv_sel == '0) begin
         ax_out = 1'b0;
      end else if (d_sel[32]) begin
         ax_out = 1'b1;
      end else if ((l_full[63:32] > dm1_sel) ||
                   ((l_full[63:32] == dm1_sel) && (l_full[31:0] != '0))) begin
         ax_out = 1'b1;
      end else if (l_full[63:32] == dm1_sel) begin
         // exactly on the upper face: last cell, full upper weight
         ax_base = BASE_W'(dm1_sel - 32'd1);
         ax_frac = ONE_Q16;
      end else begin
         ax_base = l_full[32+BASE_W-1:32];
         ax_frac = {1'b0, l_full[31:16]};
      end
   end

   always_comb begin
      wx = corner_ff[0] ? frac_ff[0] : ONE_Q16 - frac_ff[0];
      wy = corner_ff[1] ? frac_ff[1] : ONE_Q16 - frac_ff[1];
      wz = corner_ff[2] ? frac_ff[2] : ONE_Q16 - frac_ff[2];
      row_addr   = STORE_AW'(base_ff[1]) + STORE_AW'(DIM_Y) * STORE_AW'(base_ff[2]);
      corner_off = (corner_ff[0] ? STORE_AW'(1) : '0) +
                   (corner_ff[1] ? OFF_Y : '0) +
                   (corner_ff[2] ? OFF_Z : '0);
      rd_addr    = base_addr_ff + corner_off;
      prod_acc   = prod[ACC_W-1:0];
      for (int k = 0; k < 3; k++) begin
         // truncate toward zero on the divide by 65536
         rounded[k] = acc_ff[k] + {18'b0, {16{acc_ff[k][ACC_W-1]}}};
      end
   end

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      corner_in    = corner_ff;
      d_in         = d_ff;
      base_in      = base_ff;
      frac_in      = frac_ff;
      outside_in   = outside_ff;
      l_lo_in      = l_lo_ff;
      base_addr_in = base_addr_ff;
      w_in         = w_ff;
      acc_in       = acc_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      mul_op       = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start_query) begin
               d_in[0]    = {req_data.pos_x[31], req_data.pos_x} -
                            {origin[0][31], origin[0]};
               d_in[1]    = {req_data.pos_y[31], req_data.pos_y} -
                            {origin[1][31], origin[1]};
               d_in[2]    = {req_data.pos_z[31], req_data.pos_z} -
                            {origin[2][31], origin[2]};
               outside_in = 1'b0;
               ax_in      = AX_X;
               state_in   = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            mul_op.a = {1'b0, d_sel[31:0]};
            mul_op.b = {2'b0, inv_sel[15:0]};
            state_in = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            mul_op.a = {1'b0, d_sel[31:0]};
            mul_op.b = {2'b0, inv_sel[31:16]};
            l_lo_in  = prod[47:0];
            state_in = ST_AXIS;
         end
         ST_AXIS: begin
            case (ax_ff)
               AX_X: begin
                  base_in[0] = ax_base;
                  frac_in[0] = ax_frac;
               end
               AX_Y: begin
                  base_in[1] = ax_base;
                  frac_in[1] = ax_frac;
               end
               default: begin
                  base_in[2] = ax_base;
                  frac_in[2] = ax_frac;
               end
            endcase
            outside_in = outside_ff | ax_out;
            if (ax_ff == AX_Z) begin
               state_in = outside_in ? ST_DONE : ST_ADDR;
            end else begin
               ax_in    = ax_ff + 2'd1;
               state_in = ST_MUL_LO;
            end
         end
         ST_ADDR: begin
            base_addr_in = STORE_AW'(base_ff[0]) + STORE_AW'(DIM_X) * row_addr;
            acc_in       = '0;
            corner_in    = '0;
            state_in     = ST_WXY;
         end
         ST_WXY: begin
            mul_op.a = {16'b0, wx};
            mul_op.b = {1'b0, wy};
            state_in = ST_WZ;
         end
         ST_WZ: begin
            mul_op.a = prod[32:0];
            mul_op.b = {1'b0, wz};
            state_in = ST_VX;
         end
         ST_VX: begin
            w_in     = prod[48:32];
            mul_op.a = {16'b0, prod[48:32]};
            mul_op.b = {{2{rd_data.vx[15]}}, rd_data.vx};
            state_in = ST_VY;
         end
         ST_VY: begin
            acc_in[0] = acc_ff[0] + prod_acc;
            mul_op.a  = {16'b0, w_ff};
            mul_op.b  = {{2{rd_data.vy[15]}}, rd_data.vy};
            state_in  = ST_VZ;
         end
         ST_VZ: begin
            acc_in[1] = acc_ff[1] + prod_acc;
            mul_op.a  = {16'b0, w_ff};
            mul_op.b  = {{2{rd_data.vz[15]}}, rd_data.vz};
            state_in  = ST_NEXT;
         end
         ST_NEXT: begin
            acc_in[2] = acc_ff[2] + prod_acc;
            if (corner_ff == 3'd7) begin
               state_in = ST_DONE;
            end else begin
               corner_in = corner_ff + 3'd1;
               state_in  = ST_WXY;
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            if (outside_ff) begin
               rsp_data_in = '0;
            end else begin
               rsp_data_in.inside_res = 1'b1;
               rsp_data_in.out_vx     = rounded[0][31:16];
               rsp_data_in.out_vy     = rounded[1][31:16];
               rsp_data_in.out_vz     = rounded[2][31:16];
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ax_ff        <= ax_in;
      corner_ff    <= corner_in;
      d_ff         <= d_in;
      base_ff      <= base_in;
      frac_ff      <= frac_in;
      outside_ff   <= outside_in;
      l_lo_ff      <= l_lo_in;
      base_addr_ff <= base_addr_in;
      w_ff         <= w_in;
      acc_ff       <= acc_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
